FILE: design/lfre_pkg.sv
// Package for the LED frame rotate and encode block.
// Holds sizes, input kind codes, register indices, controller state type and command/status structs; no dependencies.
`timescale 1ns / 1ps

package lfre_pkg;

  localparam int MaxPixels    = 256;
  localparam int BitsPerPixel = 24;
  localparam int AddrW        = $clog2(MaxPixels);
  localparam int LenW         = $clog2(MaxPixels + 1);
  localparam int BitW         = $clog2(BitsPerPixel);

  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_ENCODE   = 2'd1;
  localparam logic [1:0] KIND_ROTATE   = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] REG_CMP_SET      = 2'd1;
  localparam logic [1:0] REG_CMP_CLEAR    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENC_READ,
    ST_ENC_EMIT,
    ST_MOD,
    ST_ROT_READ,
    ST_ROT_WAIT,
    ST_ROT_COPY
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_item;   // capture input beat
    logic mod_start;   // begin amount mod length
    logic mem_rd_src;  // read the rotation buffer at the current index
    logic capture_px;  // register pixel read data
    logic shift_bit;   // advance to next pixel bit
    logic rot_step;    // store rotated entry and advance index
    logic rot_wr;      // write back from buffer
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mod_done;
    logic rot_null;    // rotation leaves store unchanged
    logic rot_last;    // last entry of this phase
    logic bit_last;
  } status_t;

endpackage

FILE: design/lfre_if.sv
// Valid/ready stream interfaces for the input channel and the result channel.
// Depends on nothing; each interface carries the payload fields of its channel.
`timescale 1ns / 1ps

interface lfre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  position;
  logic [31:0] pixel_word;
  logic [15:0] amount;
  modport source (output valid, kind, position, pixel_word, amount, input ready);
  modport sink   (input valid, kind, position, pixel_word, amount, output ready);
endinterface

interface lfre_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_value;
  logic        last_bit;
  modport source (output valid, compare_value, last_bit, input ready);
  modport sink   (input valid, compare_value, last_bit, output ready);
endinterface

FILE: design/lfre_ctrl.sv
// Controller state machine for the LED frame block.
// Depends on lfre_pkg for state and command types.
`timescale 1ns / 1ps

module lfre_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_kind,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  lfre_pkg::status_t  status,
  output lfre_pkg::cmd_t     cmd
);

  lfre_pkg::state_t state, state_next;
  logic             rot_phase2, rot_phase2_next;
  logic             accept;

  assign accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    rot_phase2_next = rot_phase2;
    unique case (state)
      lfre_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == lfre_pkg::KIND_ENCODE) state_next = lfre_pkg::ST_ENC_READ;
          else if (in_kind == lfre_pkg::KIND_ROTATE) state_next = lfre_pkg::ST_MOD;
        end
      end
      lfre_pkg::ST_ENC_READ: state_next = lfre_pkg::ST_ENC_EMIT;
      lfre_pkg::ST_ENC_EMIT: begin
        if (out_ready && status.bit_last) state_next = lfre_pkg::ST_IDLE;
      end
      lfre_pkg::ST_MOD: begin
        if (status.mod_done) begin
          rot_phase2_next = 1'b0;
          state_next = status.rot_null ? lfre_pkg::ST_IDLE : lfre_pkg::ST_ROT_READ;
        end
      end
      lfre_pkg::ST_ROT_READ: state_next = lfre_pkg::ST_ROT_WAIT;
      lfre_pkg::ST_ROT_WAIT: state_next = lfre_pkg::ST_ROT_COPY;
      lfre_pkg::ST_ROT_COPY: begin
        state_next = lfre_pkg::ST_ROT_READ;
        if (status.rot_last) begin
          if (rot_phase2) state_next = lfre_pkg::ST_IDLE;
          else rot_phase2_next = 1'b1;
        end
      end
      default: state_next = lfre_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      lfre_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_valid;
        cmd.mod_start = in_valid && (in_kind == lfre_pkg::KIND_ROTATE);
      end
      lfre_pkg::ST_ENC_READ: cmd.capture_px = 1'b1;
      lfre_pkg::ST_ENC_EMIT: begin
        out_valid = 1'b1;
        cmd.shift_bit = out_ready;
      end
      lfre_pkg::ST_ROT_READ: cmd.mem_rd_src = 1'b1;
      lfre_pkg::ST_ROT_COPY: begin
        cmd.rot_step = !rot_phase2;
        cmd.rot_wr = rot_phase2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfre_pkg::ST_IDLE;
      rot_phase2 <= 1'b0;
    end else begin
      state <= state_next;
      rot_phase2 <= rot_phase2_next;
    end
  end

endmodule

FILE: design/lfre_datapath.sv
// Datapath: pixel memory, rotation buffer, modulo unit and bit encoder.
// Depends on lfre_pkg for sizes and the command and status structs.
`timescale 1ns / 1ps

module lfre_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_position,
  input  logic [31:0]          in_pixel_word,
  input  logic [15:0]          in_amount,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  lfre_pkg::cmd_t       cmd,
  output lfre_pkg::status_t    status,
  output logic [15:0]          compare_value,
  output logic                 last_bit
);

  localparam int AW = lfre_pkg::AddrW;
  localparam int LW = lfre_pkg::LenW;
  localparam int BW = lfre_pkg::BitW;

  logic [LW-1:0]  frame_length;
  logic [15:0]    cmp_set, cmp_clear;
  logic [31:0]    mem [lfre_pkg::MaxPixels];
  logic [31:0]    tmp [lfre_pkg::MaxPixels];
  logic [31:0]    rd_data;
  logic [31:0]    px;
  logic [BW-1:0]  bit_idx;
  logic [LW-1:0]  len;
  logic [LW-1:0]  len_eff;
  logic [16:0]    rem;          // running remainder, restoring division
  logic [4:0]     mod_cnt;
  logic [LW-1:0]  idx, src;
  logic [LW:0]    src_sum;
  logic [AW-1:0]  rd_addr;
  logic           mod_busy;
  logic [16:0]    trial;
  logic [15:0]    in_amount_r;
  logic [AW-1:0]  in_pos_r;
  logic           write_go;
  logic [31:0]    tmp_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= LW'(lfre_pkg::MaxPixels);
      cmp_set <= '0;
      cmp_clear <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lfre_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data[LW-1:0];
        lfre_pkg::REG_CMP_SET:      cmp_set <= cfg_data;
        lfre_pkg::REG_CMP_CLEAR:    cmp_clear <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_eff = (frame_length > LW'(lfre_pkg::MaxPixels))
                   ? LW'(lfre_pkg::MaxPixels) : frame_length;

  // Amount mod length, one quotient bit per cycle (restoring).
  assign trial = {rem[15:0], in_amount_r[15 - mod_cnt[3:0]]} - 17'(len);
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
      mod_cnt <= '0;
    end else if (cmd.mod_start) begin
      mod_busy <= 1'b1;
      mod_cnt <= '0;
    end else if (mod_busy) begin
      mod_cnt <= mod_cnt + 5'd1;
      if (mod_cnt == 5'd15) mod_busy <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      rem <= '0;
      len <= len_eff;
      in_amount_r <= in_amount;
    end else if (mod_busy) begin
      if (!trial[16]) rem <= trial;
      else rem <= {rem[15:0], in_amount_r[15 - mod_cnt[3:0]]};
    end
  end

  assign status.mod_done = !mod_busy && (mod_cnt == 5'd16);
  assign status.rot_null = (len <= LW'(1)) || (rem[LW-1:0] == '0) || (rem[16:LW] != '0);
  assign status.bit_last = (bit_idx == BW'(lfre_pkg::BitsPerPixel - 1));
  assign status.rot_last = (idx == len - LW'(1));

  // Source index for rotation: (idx + shift) wrapped at len.
  assign src_sum = {1'b0, idx} + {1'b0, rem[LW-1:0]};
  assign src = (src_sum >= {1'b0, len}) ? LW'(src_sum - {1'b0, len}) : src_sum[LW-1:0];

  assign rd_addr = cmd.capture_px ? in_pos_r : src[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_item) in_pos_r <= in_position;
  end
  assign write_go = cmd.load_item && (in_kind == lfre_pkg::KIND_WRITE);

  // Pixel memory: one write port, two registered read ports (this one and the encoder's).
  always_ff @(posedge clk) begin
    if (write_go) mem[in_position] <= in_pixel_word;
    else if (cmd.rot_wr) mem[idx[AW-1:0]] <= tmp_rd;
    rd_data <= mem[rd_addr];
  end

  // Rotation buffer memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rot_step) tmp[idx[AW-1:0]] <= rd_data;
    if (cmd.mem_rd_src) tmp_rd <= tmp[idx[AW-1:0]];
  end

  // Index over the frame: gathering phase, then write-back phase.
  always_ff @(posedge clk) begin
    if (cmd.mod_start) idx <= '0;
    else if (cmd.rot_step || cmd.rot_wr) idx <= status.rot_last ? '0 : idx + LW'(1);
  end

  // Encoder: pixel register and bit counter.
  always_ff @(posedge clk) begin
    if (rst) bit_idx <= '0;
    else if (cmd.capture_px) bit_idx <= '0;
    else if (cmd.shift_bit) bit_idx <= status.bit_last ? '0 : bit_idx + BW'(1);
  end
  always_ff @(posedge clk) begin
    if (cmd.capture_px) px <= mem[in_pos_r];
  end

  assign compare_value = px[bit_idx] ? cmp_set : cmp_clear;
  assign last_bit = status.bit_last;

endmodule

FILE: design/led_frame_rotate_encode.sv
// Top level of the LED frame rotate and encode block.
// Depends on lfre_pkg, lfre_if, lfre_ctrl and lfre_datapath.
`timescale 1ns / 1ps

// Write items are written to memory in the cycle they are accepted. Encode
// items read the pixel in ST_ENC_READ, then stream 24 compare beats at one
// per cycle under output ready. Rotate items run the bit-serial modulo unit
// in ST_MOD, then pass each frame entry through ST_ROT_READ, ST_ROT_WAIT and
// ST_ROT_COPY for the gather into the buffer and again for write-back; a null rotation returns to idle after ST_MOD.
// Each entry costs one registered read: the pixel memory in gather, the buffer in write-back.
module led_frame_rotate_encode (
  input  logic        clk,
  input  logic        rst,
  lfre_in_if.sink     in_ch,
  lfre_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lfre_pkg::cmd_t    cmd;
  lfre_pkg::status_t status;

  lfre_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_kind (in_ch.kind), .in_ready (in_ch.ready),
    .out_ready (out_ch.ready), .out_valid (out_ch.valid),
    .status, .cmd
  );

  lfre_datapath u_dp (
    .clk, .rst,
    .in_kind (in_ch.kind), .in_position (in_ch.position),
    .in_pixel_word (in_ch.pixel_word), .in_amount (in_ch.amount),
    .cfg_we, .cfg_index, .cfg_data,
    .cmd, .status,
    .compare_value (out_ch.compare_value), .last_bit (out_ch.last_bit)
  );

endmodule

FILE: test/tb.sv
// Testbench for the LED frame rotate and encode block.
// Depends on lfre_pkg, lfre_in_if, lfre_out_if and led_frame_rotate_encode.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  position;
    logic [31:0] pixel_word;
    logic [15:0] amount;
  } pixel_cmd_t;

  typedef struct packed {
    logic [15:0] compare_value;
    logic        last_bit;
  } bit_code_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lfre_pkg::REG_FRAME_LENGTH;
  logic [15:0] cfg_data = '0;

  lfre_in_if  in_ch ();
  lfre_out_if out_ch ();

  led_frame_rotate_encode u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: mirrored frame, written flags and registers.
  logic [31:0] frame_mirror [lfre_pkg::MaxPixels];
  bit          written [lfre_pkg::MaxPixels];
  logic [8:0]  frame_len_q;
  logic [15:0] cmp_set_q, cmp_clear_q;

  pixel_cmd_t pending_cmds[$];
  bit_code_t  expected_codes[$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  mismatches = 0;
  longint cycles = 0;

  // Updates the mirror for one accepted beat and queues its compare codes.
  task automatic predict_frame_op(input pixel_cmd_t c);
    logic [31:0] tmp [lfre_pkg::MaxPixels];
    bit          wtmp [lfre_pkg::MaxPixels];
    int len, sh, src;
    logic [31:0] px;
    bit_code_t code;
    case (c.kind)
      lfre_pkg::KIND_WRITE: begin
        frame_mirror[c.position] = c.pixel_word;
        written[c.position] = 1'b1;
      end
      lfre_pkg::KIND_ROTATE: begin
        len = (frame_len_q > lfre_pkg::MaxPixels) ? lfre_pkg::MaxPixels : frame_len_q;
        if (len > 1 && c.amount != 0) begin
          sh = c.amount % len;
          for (int j = 0; j < len; j++) begin
            src = j + sh;
            if (src >= len) src -= len;
            tmp[j] = frame_mirror[src];
            wtmp[j] = written[src];
          end
          for (int j = 0; j < len; j++) begin
            frame_mirror[j] = tmp[j];
            written[j] = wtmp[j];
          end
        end
      end
      lfre_pkg::KIND_ENCODE: begin
        px = frame_mirror[c.position];
        for (int i = 0; i < lfre_pkg::BitsPerPixel; i++) begin
          code.compare_value = px[i] ? cmp_set_q : cmp_clear_q;
          code.last_bit = (i == lfre_pkg::BitsPerPixel - 1);
          expected_codes.push_back(code);
        end
      end
      default: ;
    endcase
  endtask

  // Driver: presents queued beats, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid      <= 1'b0;
      in_ch.kind       <= lfre_pkg::KIND_WRITE;
      in_ch.position   <= '0;
      in_ch.pixel_word <= '0;
      in_ch.amount     <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_frame_op(pending_cmds.pop_front());
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= pending_cmds[0].kind;
        in_ch.position   <= pending_cmds[0].position;
        in_ch.pixel_word <= pending_cmds[0].pixel_word;
        in_ch.amount     <= pending_cmds[0].amount;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result beat and draws random stalls.
  always @(posedge clk) begin
    bit_code_t want;
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: cmp=%h last=%b", out_ch.compare_value,
                     out_ch.last_bit);
        end else begin
          want = expected_codes.pop_front();
          if (out_ch.compare_value !== want.compare_value ||
              out_ch.last_bit !== want.last_bit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want cmp=%h last=%b got cmp=%h last=%b",
                       want.compare_value, want.last_bit,
                       out_ch.compare_value, out_ch.last_bit);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycles > 1500000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic pixel_cmd_t make_cmd(logic [1:0] k, logic [7:0] p,
                                          logic [31:0] w, logic [15:0] a);
    pixel_cmd_t c;
    c.kind = k; c.position = p; c.pixel_word = w; c.amount = a;
    return c;
  endfunction

  // Returns a position already written, so no unwritten entry is encoded.
  function automatic logic [7:0] written_pos();
    logic [7:0] p;
    do p = 8'($urandom_range(255)); while (!written[p]);
    return p;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lfre_pkg::REG_FRAME_LENGTH: frame_len_q = val[8:0];
      lfre_pkg::REG_CMP_SET:      cmp_set_q = val;
      lfre_pkg::REG_CMP_CLEAR:    cmp_clear_q = val;
      default: ;
    endcase
  endtask

  // Waits until everything queued is sent and answered, then lets a
  // full rotation drain before any register write.
  task automatic drain();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_codes.size() > 0)
      @(posedge clk);
    repeat (1700) @(posedge clk);
  endtask

  // Sends a mix of beats; encodes only target written entries.
  task automatic random_phase(input int n);
    int r;
    pixel_cmd_t c;
    // Written flags change when a beat is accepted, so each beat is chosen
    // only after the one before it has been taken.
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40)
        c = make_cmd(lfre_pkg::KIND_WRITE, 8'($urandom_range(255)), $urandom, 16'h0);
      else if (r < 80)
        c = make_cmd(lfre_pkg::KIND_ENCODE, written_pos(), $urandom, 16'($urandom));
      else if (r < 95)
        c = make_cmd(lfre_pkg::KIND_ROTATE, 8'($urandom), $urandom,
                     ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(300)));
      else
        c = make_cmd(lfre_pkg::KIND_RESERVED, 8'($urandom), $urandom, 16'($urandom));
      pending_cmds.push_back(c);
      while (pending_cmds.size() > 0) @(posedge clk);
    end
  endtask

  initial begin
    frame_len_q = 9'd256;
    cmp_set_q = '0;
    cmp_clear_q = '0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Fill the low part of the frame so the directed encodes see written entries.
    for (int i = 0; i < 32; i++)
      pending_cmds.push_back(make_cmd(lfre_pkg::KIND_WRITE, 8'(i), $urandom, 16'h0));
    drain();
    write_reg(lfre_pkg::REG_CMP_SET, 16'hFFFF);
    write_reg(lfre_pkg::REG_CMP_CLEAR, 16'h0000);
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'd256);

    // Directed: extremes, every kind and the special cases.
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_WRITE, 8'd0, 32'hFFFFFFFF, 16'h0));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_WRITE, 8'd255, 32'h00000000, 16'h0));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_WRITE, 8'd7, 32'hA5A5A5A5, 16'hFFFF));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd0, 32'h0, 16'h0));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd255, 32'hFFFFFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd7, 32'h0, 16'h0));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'd0, 32'h0, 16'd0));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'd0, 32'h0, 16'd256));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'hFF, 32'hFFFFFFFF, 16'd1));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd255, 32'h0, 16'h0));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'd0, 32'h0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_RESERVED, 8'd0, 32'h12345678, 16'd5));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd0, 32'h0, 16'h0));
    drain();
    // Short frames and an oversized length.
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'd1);
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'd0, 32'h0, 16'd3));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd0, 32'h0, 16'h0));
    drain();
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'd0);
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'd0, 32'h0, 16'd3));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd1, 32'h0, 16'h0));
    drain();
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'h01FF);
    write_reg(lfre_pkg::REG_CMP_SET, 16'h0000);
    write_reg(lfre_pkg::REG_CMP_CLEAR, 16'hFFFF);
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ROTATE, 8'd0, 32'h0, 16'd3));
    pending_cmds.push_back(make_cmd(lfre_pkg::KIND_ENCODE, 8'd2, 32'h0, 16'h0));
    drain();

    // Random phases under three idling profiles and varied settings.
    send_idle_pct = 24; recv_idle_pct = 72;
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'd2);
    write_reg(lfre_pkg::REG_CMP_SET, 16'($urandom));
    write_reg(lfre_pkg::REG_CMP_CLEAR, 16'($urandom));
    random_phase(44);
    drain();
    send_idle_pct = 72; recv_idle_pct = 24;
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'($urandom_range(3, 40)));
    write_reg(lfre_pkg::REG_CMP_SET, 16'($urandom));
    write_reg(lfre_pkg::REG_CMP_CLEAR, 16'($urandom));
    random_phase(44);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(lfre_pkg::REG_FRAME_LENGTH, 16'($urandom_range(100, 256)));
    write_reg(lfre_pkg::REG_CMP_SET, 16'($urandom));
    write_reg(lfre_pkg::REG_CMP_CLEAR, 16'($urandom));
    random_phase(44);
    drain();

    if (mismatches == 0 && expected_codes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
design/lfre_pkg.sv
design/lfre_if.sv
design/lfre_ctrl.sv
design/lfre_datapath.sv
design/led_frame_rotate_encode.sv
test/tb.sv
